// ===== rtl/bfa_pkg.sv =====
// ----------------------------------------------------------------------------
// bfa_pkg
// Shared constants, codes and control types of the bitmap first-fit allocator.
// ----------------------------------------------------------------------------
package bfa_pkg;

  localparam int NUM_UNITS     = 4096;
  localparam int MAP_WORD_BITS = 64;
  localparam int MAP_WORDS     = NUM_UNITS / MAP_WORD_BITS;
  localparam int UNIT_W        = $clog2(NUM_UNITS);
  localparam int WORD_W        = $clog2(MAP_WORDS);
  localparam int BIT_W         = $clog2(MAP_WORD_BITS);
  localparam int REG_W         = 13;
  localparam int ACT_W         = 2;
  localparam int STAT_W        = 2;
  localparam int CFG_IDX_W     = 1;

  localparam logic [ACT_W-1:0] ACT_ALLOC   = 2'd0;
  localparam logic [ACT_W-1:0] ACT_RELEASE = 2'd1;
  localparam logic [ACT_W-1:0] ACT_MARK    = 2'd2;

  localparam logic [STAT_W-1:0] ST_DONE    = 2'd0;
  localparam logic [STAT_W-1:0] ST_FULL    = 2'd1;
  localparam logic [STAT_W-1:0] ST_IGNORED = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_RANGE_START = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_RANGE_END   = 1'd1;

  localparam logic [REG_W-1:0] RANGE_START_RST = 13'd0;
  localparam logic [REG_W-1:0] RANGE_END_RST   = 13'd4096;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_SCAN,
    S_UPDATE,
    S_RESP
  } state_t;

  typedef struct packed {
    logic              load;
    logic              rd_first;
    logic              rd_idx;
    logic              rd_next;
    logic              wr_alloc;
    logic              wr_update;
    logic              res_we;
    logic [STAT_W-1:0] res_status;
    logic              out_load;
  } cmd_t;

  typedef struct packed {
    logic [ACT_W-1:0] action;
    logic             empty;
    logic             rel_ok;
    logic             mark_ok;
    logic             hit;
    logic             last;
    logic             out_free;
  } status_t;

endpackage

// ===== rtl/bfa_if.sv =====
// ----------------------------------------------------------------------------
// bfa_if
// Valid/ready channels of the allocator: request items and result items.
// ----------------------------------------------------------------------------
interface bfa_in_if;
  logic                       valid;
  logic                       ready;
  logic [bfa_pkg::ACT_W-1:0]  action;
  logic [bfa_pkg::UNIT_W-1:0] unit_index;

  modport source (output valid, output action, output unit_index, input ready);
  modport sink   (input valid, input action, input unit_index, output ready);
endinterface

interface bfa_out_if;
  logic                       valid;
  logic                       ready;
  logic [bfa_pkg::UNIT_W-1:0] granted_index;
  logic [bfa_pkg::STAT_W-1:0] status;

  modport source (output valid, output granted_index, output status, input ready);
  modport sink   (input valid, input granted_index, input status, output ready);
endinterface

// ===== rtl/bfa_ctrl.sv =====
// ----------------------------------------------------------------------------
// bfa_ctrl
// Request sequencer: decodes an item, steps the word scan, issues map
// writes and hands the result to the output register.
// ----------------------------------------------------------------------------
module bfa_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  bfa_pkg::status_t st,
  output bfa_pkg::cmd_t    cmd
);

  bfa_pkg::state_t state_r;
  bfa_pkg::state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= bfa_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    unique case (state_r)
      bfa_pkg::S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = bfa_pkg::S_DECODE;
        end
      end
      bfa_pkg::S_DECODE: begin
        unique case (st.action)
          bfa_pkg::ACT_ALLOC: begin
            if (st.empty) begin
              cmd.res_we     = 1'b1;
              cmd.res_status = bfa_pkg::ST_FULL;
              state_nxt      = bfa_pkg::S_RESP;
            end else begin
              cmd.rd_first = 1'b1;
              state_nxt    = bfa_pkg::S_SCAN;
            end
          end
          bfa_pkg::ACT_RELEASE: begin
            if (st.rel_ok) begin
              cmd.rd_idx = 1'b1;
              state_nxt  = bfa_pkg::S_UPDATE;
            end else begin
              cmd.res_we     = 1'b1;
              cmd.res_status = bfa_pkg::ST_IGNORED;
              state_nxt      = bfa_pkg::S_RESP;
            end
          end
          bfa_pkg::ACT_MARK: begin
            if (st.mark_ok) begin
              cmd.rd_idx = 1'b1;
              state_nxt  = bfa_pkg::S_UPDATE;
            end else begin
              cmd.res_we     = 1'b1;
              cmd.res_status = bfa_pkg::ST_IGNORED;
              state_nxt      = bfa_pkg::S_RESP;
            end
          end
          default: begin
            cmd.res_we     = 1'b1;
            cmd.res_status = bfa_pkg::ST_IGNORED;
            state_nxt      = bfa_pkg::S_RESP;
          end
        endcase
      end
      bfa_pkg::S_SCAN: begin
        if (st.hit) begin
          cmd.wr_alloc   = 1'b1;
          cmd.res_we     = 1'b1;
          cmd.res_status = bfa_pkg::ST_DONE;
          state_nxt      = bfa_pkg::S_RESP;
        end else if (st.last) begin
          cmd.res_we     = 1'b1;
          cmd.res_status = bfa_pkg::ST_FULL;
          state_nxt      = bfa_pkg::S_RESP;
        end else begin
          cmd.rd_next = 1'b1;
        end
      end
      bfa_pkg::S_UPDATE: begin
        cmd.wr_update  = 1'b1;
        cmd.res_we     = 1'b1;
        cmd.res_status = bfa_pkg::ST_DONE;
        state_nxt      = bfa_pkg::S_RESP;
      end
      bfa_pkg::S_RESP: begin
        if (st.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = bfa_pkg::S_IDLE;
        end
      end
      default: begin
        state_nxt = bfa_pkg::S_IDLE;
      end
    endcase
  end

endmodule

// ===== rtl/bfa_dp.sv =====
// ----------------------------------------------------------------------------
// bfa_dp
// Datapath: range registers, used/free map memory with per-row valid bits,
// range masking, lowest-free priority encoder and output register.
// ----------------------------------------------------------------------------
module bfa_dp (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [bfa_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [bfa_pkg::REG_W-1:0]     cfg_wdata,
  input  logic [bfa_pkg::ACT_W-1:0]     in_action,
  input  logic [bfa_pkg::UNIT_W-1:0]    in_unit_index,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [bfa_pkg::UNIT_W-1:0]    out_granted_index,
  output logic [bfa_pkg::STAT_W-1:0]    out_status,
  input  bfa_pkg::cmd_t                 cmd,
  output bfa_pkg::status_t              st
);

  localparam int MWB = bfa_pkg::MAP_WORD_BITS;
  localparam int UW  = bfa_pkg::UNIT_W;
  localparam int WW  = bfa_pkg::WORD_W;
  localparam int BW  = bfa_pkg::BIT_W;
  localparam int RW  = bfa_pkg::REG_W;

  logic [RW-1:0]                  range_start_r;
  logic [RW-1:0]                  range_end_r;
  logic [bfa_pkg::ACT_W-1:0]      action_r;
  logic [UW-1:0]                  idx_r;
  logic [MWB-1:0]                 map_mem_r [bfa_pkg::MAP_WORDS];
  logic [bfa_pkg::MAP_WORDS-1:0]  row_valid_r;
  logic [MWB-1:0]                 rdata_r;
  logic                           rvld_r;
  logic [WW-1:0]                  rd_word_r;
  logic [UW-1:0]                  res_grant_r;
  logic [bfa_pkg::STAT_W-1:0]     res_status_r;
  logic                           out_valid_r;
  logic [UW-1:0]                  out_grant_r;
  logic [bfa_pkg::STAT_W-1:0]     out_status_r;

  logic [RW-1:0]  end_c;
  logic [RW-1:0]  end_m1;
  logic [WW-1:0]  start_word;
  logic [WW-1:0]  last_word;
  logic           rd_en;
  logic [WW-1:0]  raddr;
  logic           wr_en;
  logic [WW-1:0]  waddr;
  logic [MWB-1:0] wdata;
  logic [MWB-1:0] word_eff;
  logic [MWB-1:0] lo_mask;
  logic [MWB-1:0] hi_mask;
  logic [MWB-1:0] cand;
  logic [BW-1:0]  hit_pos;
  logic [MWB-1:0] idx_bit;
  logic [MWB-1:0] hit_bit;

  // configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      range_start_r <= bfa_pkg::RANGE_START_RST;
      range_end_r   <= bfa_pkg::RANGE_END_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        bfa_pkg::CFG_RANGE_START: range_start_r <= cfg_wdata;
        bfa_pkg::CFG_RANGE_END:   range_end_r   <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign end_c      = (range_end_r > RW'(bfa_pkg::NUM_UNITS)) ?
                      RW'(bfa_pkg::NUM_UNITS) : range_end_r;
  assign end_m1     = end_c - RW'(1);
  assign start_word = range_start_r[UW-1:BW];
  assign last_word  = end_m1[UW-1:BW];

  // request capture
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      action_r <= in_action;
      idx_r    <= in_unit_index;
    end
  end

  // map read side
  assign rd_en = cmd.rd_first | cmd.rd_idx | cmd.rd_next;

  always_comb begin
    if (cmd.rd_first) begin
      raddr = start_word;
    end else if (cmd.rd_idx) begin
      raddr = idx_r[UW-1:BW];
    end else begin
      raddr = rd_word_r + WW'(1);
    end
  end

  assign word_eff = rvld_r ? rdata_r : '0;

  // range mask and lowest-free search
  assign lo_mask = (rd_word_r == start_word) ?
                   ({MWB{1'b1}} << range_start_r[BW-1:0]) : {MWB{1'b1}};
  assign hi_mask = ((rd_word_r == last_word) && (end_c[BW-1:0] != '0)) ?
                   ~({MWB{1'b1}} << end_c[BW-1:0]) : {MWB{1'b1}};
  assign cand    = ~word_eff & lo_mask & hi_mask;

  always_comb begin
    hit_pos = '0;
    for (int i = MWB - 1; i >= 0; i--) begin
      if (cand[i]) begin
        hit_pos = BW'(i);
      end
    end
  end

  assign hit_bit = MWB'(1) << hit_pos;
  assign idx_bit = MWB'(1) << idx_r[BW-1:0];

  // map write side
  assign wr_en = cmd.wr_alloc | cmd.wr_update;

  always_comb begin
    if (cmd.wr_alloc) begin
      waddr = rd_word_r;
      wdata = word_eff | hit_bit;
    end else begin
      waddr = idx_r[UW-1:BW];
      wdata = (action_r == bfa_pkg::ACT_RELEASE) ? (word_eff & ~idx_bit)
                                                 : (word_eff | idx_bit);
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      map_mem_r[waddr] <= wdata;
    end
    if (rd_en) begin
      rdata_r   <= map_mem_r[raddr];
      rvld_r    <= row_valid_r[raddr];
      rd_word_r <= raddr;
    end
  end

  // unwritten rows read as all free
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_valid_r <= '0;
    end else if (wr_en) begin
      row_valid_r[waddr] <= 1'b1;
    end
  end

  // result
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      res_grant_r <= '0;
    end else if (cmd.wr_alloc) begin
      res_grant_r <= {rd_word_r, hit_pos};
    end
    if (cmd.res_we) begin
      res_status_r <= cmd.res_status;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_grant_r  <= res_grant_r;
      out_status_r <= res_status_r;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_granted_index = out_grant_r;
  assign out_status        = out_status_r;

  assign st.action   = action_r;
  assign st.empty    = range_start_r >= end_c;
  assign st.rel_ok   = {1'b0, idx_r} < end_c;
  assign st.mark_ok  = {1'b0, idx_r} < RW'(bfa_pkg::NUM_UNITS);
  assign st.hit      = |cand;
  assign st.last     = rd_word_r == last_word;
  assign st.out_free = !out_valid_r || out_ready;

endmodule

// ===== rtl/bitmap_first_fit_allocator.sv =====
// ----------------------------------------------------------------------------
// bitmap_first_fit_allocator
// Used/free bitmap over 4096 units with allocate, release and mark requests.
//
// Request items (action, unit_index) enter on in_ch; one result item
// (granted_index, status) per request leaves on out_ch. Both are valid/ready.
// The cfg port writes range_start (index 0) and range_end (index 1); write
// only while no request is in flight.
// One request is worked at a time. The map is held as 64 words of 64 bits in
// a single-port-read memory; allocate reads one word per cycle and picks the
// lowest free unit in the word with a priority encoder.
// Release and mark pass through decode, update and response states; an
// allocate passes through decode, a scan step per word read and response;
// an empty range or an ignored request goes from decode to response. The
// next item is taken in the cycle after the result is loaded.
// A waiting result sits in the output register; in_ch stays open for the
// next item, which holds in its last step until the register frees.
// Reset clears the map at once through per-word valid bits and sets the
// range to the whole map.
// ----------------------------------------------------------------------------
module bitmap_first_fit_allocator (
  input  logic                          clk,
  input  logic                          rst_n,
  bfa_in_if.sink                        in_ch,
  bfa_out_if.source                     out_ch,
  input  logic                          cfg_we,
  input  logic [bfa_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [bfa_pkg::REG_W-1:0]     cfg_wdata
);

  bfa_pkg::cmd_t    cmd;
  bfa_pkg::status_t st;
  logic             in_ready;

  assign in_ch.ready = in_ready;

  bfa_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ready),
    .st       (st),
    .cmd      (cmd)
  );

  bfa_dp u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_wdata         (cfg_wdata),
    .in_action         (in_ch.action),
    .in_unit_index     (in_ch.unit_index),
    .out_valid         (out_ch.valid),
    .out_ready         (out_ch.ready),
    .out_granted_index (out_ch.granted_index),
    .out_status        (out_ch.status),
    .cmd               (cmd),
    .st                (st)
  );

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> st.out_free)
    else $error("result register overwritten");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready) |=> !in_ch.ready)
    else $error("second item taken while one is in flight");

  a_scan_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.rd_next |-> !st.last)
    else $error("scan ran past the last word of the range");

  a_grant_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && (out_ch.status != bfa_pkg::ST_DONE)) |->
      (out_ch.granted_index == '0))
    else $error("nonzero index on a failed request");

endmodule
